>>> rtl/assert_macros.svh
// assertion helpers used by ebp_datapath
// no dependencies; every macro checks on the rising clock edge with reset masking
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when the antecedent holds, the consequent holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/ebp_pkg.sv
// shared constants, codes and control structs for the entropy bit pool
// no dependencies
`default_nettype none

package ebp_pkg;

   localparam int POOL_BITS_DEF = 1024;
   localparam int PICK_BITS     = 14;
   localparam int MAX_REQ       = 32;
   localparam int DIV_STEPS     = 32;
   localparam int REQ_W         = 72;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PICK = 2'd2;

   typedef struct packed {
      logic load;
      logic push_step;
      logic pop_issue;
      logic div_load;
      logic div_from_pool;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       push_more;
      logic       pop_more;
      logic       pop_pending;
      logic       pick_ok;
      logic       wc_zero;
      logic       div_done;
      logic       slot_free;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/ebp_ctrl.sv
// controller state machine for the entropy bit pool
// depends on ebp_pkg; drives the datapath through cmd_type, watches stat_type
`default_nettype none

module ebp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire ebp_pkg::stat_type stat,
   output ebp_pkg::cmd_type       cmd
);
   import ebp_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_PUSH     = 3'd2;
   localparam logic [2:0] S_POP      = 3'd3;
   localparam logic [2:0] S_DIV      = 3'd4;
   localparam logic [2:0] S_FIN      = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_PUSH: state_in = S_PUSH;
               MODE_POP:  state_in = S_POP;
               MODE_PICK: begin
                  if (stat.wc_zero) begin
                     state_in = S_FIN;
                  end else if (stat.pick_ok) begin
                     state_in = S_POP;
                  end else begin
                     // too few pooled bits: reduce the fallback word instead
                     cmd.div_load = 1'b1;
                     state_in     = S_DIV;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end
         S_PUSH: begin
            if (stat.push_more) begin
               cmd.push_step = 1'b1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_POP: begin
            if (stat.pop_more) begin
               cmd.pop_issue = 1'b1;
            end else if (!stat.pop_pending) begin
               // last read bit has landed
               if (stat.mode == MODE_PICK) begin
                  cmd.div_load      = 1'b1;
                  cmd.div_from_pool = 1'b1;
                  state_in          = S_DIV;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FIN: begin
            if (stat.slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ebp_datapath.sv
// datapath of the entropy bit pool: bit memory, pointers, capture, divider, output register
// depends on ebp_pkg and assert_macros.svh; commanded by ebp_ctrl
`default_nettype none

module ebp_datapath #(
   parameter  int POOL_BITS = ebp_pkg::POOL_BITS_DEF,
   localparam int LVL_W     = $clog2(POOL_BITS + 1),
   localparam int RSP_W     = ((55 + LVL_W + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ebp_pkg::cmd_type          cmd,
   output ebp_pkg::stat_type              stat,
   input  wire logic [1:0]                req_tuser,
   input  wire logic [ebp_pkg::REQ_W-1:0] req_tdata,
   input  wire logic                      csr_we,
   input  wire logic [15:0]               csr_wdata,
   input  wire logic                      rsp_tready,
   output logic                           rsp_tvalid,
   output logic [RSP_W-1:0]               rsp_tdata
);
   import ebp_pkg::*;

   localparam int PTR_W = $clog2(POOL_BITS);
   localparam int PAD_W = RSP_W - 55 - LVL_W;

   logic pool_mem [POOL_BITS];
   logic rd_ff;

   logic [1:0]       mode_ff, mode_in;
   logic [5:0]       req_ff, req_in;
   logic [31:0]      val_ff, val_in;
   logic [31:0]      fb_ff, fb_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [LVL_W-1:0] fill_ff, fill_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [5:0]       cap_ff, cap_in;
   logic             pend_ff, pend_in;
   logic [31:0]      rbits_ff, rbits_in;
   logic [15:0]      rem_ff, rem_in;
   logic [31:0]      dsrc_ff, dsrc_in;
   logic [5:0]       dcnt_ff, dcnt_in;
   logic             valid_ff, valid_in;
   logic [15:0]      wc_ff, wc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [16:0]      trial;
   logic [5:0]       req_raw;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(POOL_BITS - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_raw = req_tdata[5:0];
   assign trial   = {rem_ff, dsrc_ff[31]};

   always_comb begin
      mode_in      = mode_ff;
      req_in       = req_ff;
      val_in       = val_ff;
      fb_in        = fb_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      pend_in      = cmd.pop_issue;
      rbits_in     = rbits_ff;
      rem_in       = rem_ff;
      dsrc_in      = dsrc_ff;
      dcnt_in      = dcnt_ff;
      valid_in     = valid_ff;
      wc_in        = wc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         mode_in = req_tuser;
         if (req_tuser == MODE_PICK) begin
            req_in = 6'(PICK_BITS);
         end else begin
            req_in = (req_raw > 6'(MAX_REQ)) ? 6'(MAX_REQ) : req_raw;
         end
         val_in   = req_tdata[37:6];
         fb_in    = req_tdata[69:38];
         cnt_in   = '0;
         cap_in   = '0;
         rbits_in = '0;
         rem_in   = '0;
         valid_in = 1'b0;
      end

      if (cmd.push_step) begin
         val_in  = val_ff >> 1;
         wp_in   = ptr_inc(wp_ff);
         fill_in = fill_ff + 1'b1;
         cnt_in  = cnt_ff + 1'b1;
      end

      if (cmd.pop_issue) begin
         rp_in   = ptr_inc(rp_ff);
         fill_in = fill_ff - 1'b1;
         cnt_in  = cnt_ff + 1'b1;
      end

      // memory read data arrives in the cycle after its address is issued
      if (pend_ff) begin
         rbits_in[cap_ff[4:0]] = rd_ff;
         cap_in                = cap_ff + 1'b1;
      end

      if (cmd.div_load) begin
         dsrc_in  = cmd.div_from_pool ? rbits_ff : fb_ff;
         rem_in   = '0;
         dcnt_in  = '0;
         valid_in = 1'b1;
      end

      // restoring division, one quotient bit per cycle; only the remainder is kept
      if (cmd.div_step) begin
         if (trial >= {1'b0, wc_ff}) begin
            rem_in = 16'(trial - {1'b0, wc_ff});
         end else begin
            rem_in = trial[15:0];
         end
         dsrc_in = dsrc_ff << 1;
         dcnt_in = dcnt_ff + 1'b1;
      end

      if (csr_we) begin
         wc_in = csr_wdata;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, fill_ff, valid_ff, rem_ff, cnt_ff, rbits_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_step) begin
         pool_mem[wp_ff] <= val_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= pool_mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         wc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         wc_ff        <= wc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      req_ff      <= req_in;
      val_ff      <= val_in;
      fb_ff       <= fb_in;
      cnt_ff      <= cnt_in;
      cap_ff      <= cap_in;
      rbits_ff    <= rbits_in;
      rem_ff      <= rem_in;
      dsrc_ff     <= dsrc_in;
      dcnt_ff     <= dcnt_in;
      valid_ff    <= valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.mode        = mode_ff;
      stat.push_more   = (cnt_ff < req_ff) && (fill_ff != LVL_W'(POOL_BITS));
      stat.pop_more    = (cnt_ff < req_ff) && (fill_ff != '0);
      stat.pop_pending = pend_ff;
      stat.pick_ok     = fill_ff >= LVL_W'(PICK_BITS);
      stat.wc_zero     = (wc_ff == '0);
      stat.div_done    = (dcnt_ff == 6'(DIV_STEPS));
      stat.slot_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= LVL_W'(POOL_BITS), "pool over-filled")
   `ASSERT_IMPLY(a_empty_ptrs, clock, reset, fill_ff == '0, rp_ff == wp_ff, "empty pool ptr skew")
   `ASSERT_IMPLY(a_pop_nonempty, clock, reset, cmd.pop_issue, fill_ff != '0, "pop from empty pool")

endmodule

`default_nettype wire

>>> rtl/entropy_bit_pool_index_picker.sv
// Channel  | Dir | Fields (lsb up)
// req      | in  | tuser: mode[1:0]; tdata: bit_request[5:0], push_value[37:6],
//          |     |        fallback_random[69:38]
// rsp      | out | tdata: read_bits[31:0], bits_moved[37:32], word_index[53:38],
//          |     |        index_valid[54], pool_level[55 +: LVL_W]
// csr      | in  | csr_we / csr_wdata: list size (pick modulus), written without wait
//
// one request at a time; one write and one registered read port on the bit memory: a push
// writes its bits one by one and a pop reads them one by one through the registered port;
// pick reads 14 bits from the pool when enough are pooled, else uses the fallback word,
// each with a 32-step restoring remainder loop against the list size; zero size skips both
// synchronous active-high reset clears pointers, level and list size, not the bit memory
// a result waits in the output register while the next request is taken
`default_nettype none

module entropy_bit_pool_index_picker #(
   parameter  int POOL_BITS = ebp_pkg::POOL_BITS_DEF,
   localparam int LVL_W     = $clog2(POOL_BITS + 1),
   localparam int RSP_W     = ((55 + LVL_W + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [1:0]                req_tuser,  // mode
   input  wire logic [ebp_pkg::REQ_W-1:0] req_tdata,  // bit_request, push_value, fallback_random
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // read_bits, bits_moved, word_index, index_valid, pool_level, zero pad
   output logic [RSP_W-1:0]               rsp_tdata,
   input  wire logic                      csr_we,
   input  wire logic [15:0]               csr_wdata
);
   import ebp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ebp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ebp_datapath #(
      .POOL_BITS (POOL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
